// File: hw/rtl/bpc_pkg.sv
// Shared types and constants for the barometric pressure compensation unit.
package bpc_pkg;

  localparam logic [31:0] TempOffset = 32'd4000;
  localparam logic [31:0] B4Bias     = 32'd32768;
  localparam logic [31:0] PressScale = 32'd50000;
  localparam logic [31:0] PcSq       = 32'd3038;
  localparam logic [31:0] PcLinNeg   = 32'hFFFF_E343;  // -7357
  localparam logic [31:0] PcOff      = 32'd3791;
  localparam logic [17:0] PressMax   = 18'h3FFFF;

  typedef enum logic [2:0] {
    REG_AC1_AC2 = 3'd0,
    REG_AC3_AC4 = 3'd1,
    REG_AC5_AC6 = 3'd2,
    REG_B1_B2   = 3'd3,
    REG_MC_MD   = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic signed [15:0] ac1;
    logic signed [15:0] ac2;
    logic signed [15:0] ac3;
    logic        [15:0] ac4;
    logic        [15:0] ac5;
    logic        [15:0] ac6;
    logic signed [15:0] b1;
    logic signed [15:0] b2;
    logic signed [15:0] mc;
    logic signed [15:0] md;
  } coef_t;

  // 32-bit wrapping product, low word.
  function automatic logic [31:0] mulw(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = {32'd0, a} * {32'd0, b};
    return p[31:0];
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] v, input int unsigned s);
    return 32'($signed(v) >>> s);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

endpackage

// File: hw/rtl/bpc_if.sv
// Valid/ready channel interfaces for the compensation unit.
interface bpc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] raw_temp;
  logic [15:0] raw_press;
  modport source (output valid, raw_temp, raw_press, input ready);
  modport sink   (input valid, raw_temp, raw_press, output ready);
endinterface

interface bpc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] temp_tenths;
  logic        [17:0] press_pa;
  logic               div_error;
  modport source (output valid, temp_tenths, press_pa, div_error, input ready);
  modport sink   (input valid, temp_tenths, press_pa, div_error, output ready);
endinterface

interface bpc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/barometric_pressure_compensation_unit.sv
// Top level of the barometric pressure compensation unit.
// Pipeline: two 32-stage dividers plus 20 arithmetic stages; throughput one
//   transaction per cycle while the output is not stalled.
// The whole pipeline advances on one enable; a stalled output freezes it and
//   one skid register holds the transaction taken at the input during a stall.
// Reset clears valid bits and calibration registers (all zero); payload is
//   not reset.
module barometric_pressure_compensation_unit
  import bpc_pkg::*;
#(
  parameter int unsigned NStages = 20
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bpc_in_if.sink    in_ch,
  bpc_out_if.source out_ch,
  bpc_cfg_if.sink   cfg_ch
);
  localparam int unsigned Dw = 32;
  localparam int unsigned Lat = NStages + 2 * Dw;

  // Calibration registers.
  logic [31:0] r0_q, r1_q, r2_q, r3_q, r4_q;
  coef_t c;
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r0_q <= '0; r1_q <= '0; r2_q <= '0; r3_q <= '0; r4_q <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_AC1_AC2: r0_q <= cfg_ch.data;
        REG_AC3_AC4: r1_q <= cfg_ch.data;
        REG_AC5_AC6: r2_q <= cfg_ch.data;
        REG_B1_B2:   r3_q <= cfg_ch.data;
        REG_MC_MD:   r4_q <= cfg_ch.data;
        default: ;
      endcase
    end
  end
  assign c = '{ac1: r0_q[31:16], ac2: r0_q[15:0], ac3: r1_q[31:16], ac4: r1_q[15:0],
               ac5: r2_q[31:16], ac6: r2_q[15:0], b1: r3_q[31:16], b2: r3_q[15:0],
               mc: r4_q[31:16], md: r4_q[15:0]};

  // Pipeline enable: advance unless the output holds a result not taken.
  // v_q[k] is the valid bit of the payload k+1 register stages after the input.
  logic en;
  logic [Lat-1:0] v_q;
  logic skid_v_q;
  logic [15:0] skid_t_q, skid_p_q;
  logic out_full;
  assign out_full = v_q[Lat-1] && !out_ch.ready;
  assign en = !out_full;
  assign in_ch.ready = !skid_v_q;

  logic        in_v;
  logic [15:0] in_t, in_p;
  assign in_v = skid_v_q || in_ch.valid;
  assign in_t = skid_v_q ? skid_t_q : in_ch.raw_temp;
  assign in_p = skid_v_q ? skid_p_q : in_ch.raw_press;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) skid_v_q <= 1'b0;
    else if (en) skid_v_q <= 1'b0;
    else if (in_ch.valid && in_ch.ready) skid_v_q <= 1'b1;
  end
  always_ff @(posedge clk_i) begin
    if (!en && in_ch.valid && in_ch.ready) begin
      skid_t_q <= in_ch.raw_temp;
      skid_p_q <= in_ch.raw_press;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else if (en) v_q <= {v_q[Lat-2:0], in_v};
  end

  // Stage 1: x1 product.
  logic [31:0] s1_prod_q;
  logic [15:0] s1_p_q;
  always_ff @(posedge clk_i) if (en) begin
    s1_prod_q <= mulw({16'd0, in_t} - {16'd0, c.ac6}, {16'd0, c.ac5});
    s1_p_q    <= in_p;
  end
  // Stage 2: x1, divisor, sign handling for x2 = mc*2048 / div.
  logic [31:0] s2_x1_q, s2_num_q, s2_den_q;
  logic        s2_neg_q, s2_err_q;
  logic [15:0] s2_p_q;
  logic [31:0] x1a, dv, nm;
  always_comb begin
    x1a = asr(s1_prod_q, 15);
    dv  = x1a + sx16(c.md);
    nm  = mulw(sx16(c.mc), 32'd2048);
  end
  always_ff @(posedge clk_i) if (en) begin
    s2_x1_q  <= x1a;
    s2_err_q <= (dv == '0);
    s2_num_q <= nm[31] ? -nm : nm;
    s2_den_q <= dv[31] ? -dv : dv;
    s2_neg_q <= nm[31] ^ dv[31];
    s2_p_q   <= s1_p_q;
  end

  // Divider 1 (temperature).
  localparam int unsigned S1w = 32 + 1 + 1 + 16;
  logic [31:0] d1_q;
  logic [S1w-1:0] d1_side;
  bpc_div #(.W(Dw), .SW(S1w)) u_div_t (
    .clk_i, .en_i(en), .num_i(s2_num_q), .den_i(s2_den_q),
    .side_i({s2_x1_q, s2_neg_q, s2_err_q, s2_p_q}), .quo_o(d1_q), .side_o(d1_side)
  );
  logic [31:0] d1_x1;
  logic d1_neg, d1_err;
  logic [15:0] d1_p;
  assign {d1_x1, d1_neg, d1_err, d1_p} = d1_side;

  // Stage 3: b5, b6.
  logic [31:0] s3_b5_q, s3_b6_q;
  logic s3_err_q;
  logic [15:0] s3_p_q;
  logic [31:0] b5c;
  assign b5c = d1_x1 + (d1_neg ? -d1_q : d1_q);
  always_ff @(posedge clk_i) if (en) begin
    s3_b5_q <= b5c; s3_b6_q <= b5c - TempOffset; s3_err_q <= d1_err; s3_p_q <= d1_p;
  end
  // Stage 4: b6*b6, ac2*b6, ac3*b6.
  logic [31:0] s4_sqp_q, s4_a2_q, s4_a3_q, s4_b5_q;
  logic s4_err_q;
  logic [15:0] s4_p_q;
  always_ff @(posedge clk_i) if (en) begin
    s4_sqp_q <= mulw(s3_b6_q, s3_b6_q);
    s4_a2_q  <= mulw(sx16(c.ac2), s3_b6_q);
    s4_a3_q  <= mulw(sx16(c.ac3), s3_b6_q);
    s4_b5_q  <= s3_b5_q; s4_err_q <= s3_err_q; s4_p_q <= s3_p_q;
  end
  // Stage 5: b2*sq, b1*sq.
  logic [31:0] s5_b2_q, s5_b1_q, s5_a2_q, s5_a3_q, s5_b5_q;
  logic s5_err_q;
  logic [15:0] s5_p_q;
  logic [31:0] sq;
  assign sq = asr(s4_sqp_q, 12);
  always_ff @(posedge clk_i) if (en) begin
    s5_b2_q <= mulw(sx16(c.b2), sq);
    s5_b1_q <= mulw(sx16(c.b1), sq);
    s5_a2_q <= s4_a2_q; s5_a3_q <= s4_a3_q;
    s5_b5_q <= s4_b5_q; s5_err_q <= s4_err_q; s5_p_q <= s4_p_q;
  end
  // Stage 6: b3 and x3 for b4.
  logic [31:0] s6_b3_q, s6_x3_q, s6_b5_q;
  logic s6_err_q;
  logic [15:0] s6_p_q;
  logic [31:0] x3a, x3b;
  always_comb begin
    x3a = asr(s5_b2_q, 11) + asr(s5_a2_q, 11);
    x3b = asr(asr(s5_a3_q, 13) + asr(s5_b1_q, 16) + 32'd2, 2);
  end
  always_ff @(posedge clk_i) if (en) begin
    s6_b3_q <= asr(mulw(sx16(c.ac1), 32'd4) + x3a + 32'd2, 2);
    s6_x3_q <= x3b + B4Bias;
    s6_b5_q <= s5_b5_q; s6_err_q <= s5_err_q; s6_p_q <= s5_p_q;
  end
  // Stage 7: b4 product, up - b3.
  logic [31:0] s7_b4p_q, s7_ub_q, s7_b5_q;
  logic s7_err_q;
  always_ff @(posedge clk_i) if (en) begin
    s7_b4p_q <= mulw({16'd0, c.ac4}, s6_x3_q);
    s7_ub_q  <= {16'd0, s6_p_q} - s6_b3_q;
    s7_b5_q  <= s6_b5_q; s7_err_q <= s6_err_q;
  end
  // Stage 8: b7.
  logic [31:0] s8_b4_q, s8_b7_q, s8_b5_q;
  logic s8_err_q;
  always_ff @(posedge clk_i) if (en) begin
    s8_b4_q <= s7_b4p_q >> 15;
    s8_b7_q <= mulw(s7_ub_q, PressScale);
    s8_b5_q <= s7_b5_q; s8_err_q <= s7_err_q;
  end
  // Stage 9: divider operands.
  logic [31:0] s9_num_q, s9_den_q, s9_b5_q;
  logic s9_hi_q, s9_err_q;
  always_ff @(posedge clk_i) if (en) begin
    s9_hi_q  <= s8_b7_q[31];
    s9_num_q <= s8_b7_q[31] ? s8_b7_q : {s8_b7_q[30:0], 1'b0};
    s9_den_q <= s8_b4_q;
    s9_err_q <= s8_err_q || (s8_b4_q == '0);
    s9_b5_q  <= s8_b5_q;
  end
  // Divider 2 (pressure).
  localparam int unsigned S2w = 32 + 2;
  logic [31:0] d2_q;
  logic [S2w-1:0] d2_side;
  bpc_div #(.W(Dw), .SW(S2w)) u_div_p (
    .clk_i, .en_i(en), .num_i(s9_num_q), .den_i(s9_den_q),
    .side_i({s9_b5_q, s9_hi_q, s9_err_q}), .quo_o(d2_q), .side_o(d2_side)
  );
  logic [31:0] d2_b5;
  logic d2_hi, d2_err;
  assign {d2_b5, d2_hi, d2_err} = d2_side;

  // Stage 10: p, p>>8.
  logic [31:0] s10_p_q, s10_ps_q, s10_b5_q;
  logic s10_err_q;
  logic [31:0] pc;
  assign pc = d2_hi ? {d2_q[30:0], 1'b0} : d2_q;
  always_ff @(posedge clk_i) if (en) begin
    s10_p_q <= pc; s10_ps_q <= asr(pc, 8); s10_b5_q <= d2_b5; s10_err_q <= d2_err;
  end
  // Stage 11: (p>>8)^2 and -7357*p.
  logic [31:0] s11_p_q, s11_sq_q, s11_lin_q, s11_b5_q;
  logic s11_err_q;
  always_ff @(posedge clk_i) if (en) begin
    s11_sq_q  <= mulw(s10_ps_q, s10_ps_q);
    s11_lin_q <= mulw(PcLinNeg, s10_p_q);
    s11_p_q <= s10_p_q; s11_b5_q <= s10_b5_q; s11_err_q <= s10_err_q;
  end
  // Stage 12: *3038.
  logic [31:0] s12_p_q, s12_sq_q, s12_lin_q, s12_b5_q;
  logic s12_err_q;
  always_ff @(posedge clk_i) if (en) begin
    s12_sq_q <= mulw(s11_sq_q, PcSq);
    s12_lin_q <= s11_lin_q; s12_p_q <= s11_p_q; s12_b5_q <= s11_b5_q;
    s12_err_q <= s11_err_q;
  end
  // Stage 13: final pressure and temperature, saturation (NStages rest are delay).
  logic [31:0] pf, tf;
  logic signed [15:0] tsat;
  logic [17:0] psat;
  always_comb begin
    pf = s12_p_q + asr(asr(s12_sq_q, 16) + asr(s12_lin_q, 16) + PcOff, 4);
    tf = asr(s12_b5_q + 32'd8, 4);
    if ($signed(tf) > 32'sd32767) tsat = 16'sh7FFF;
    else if ($signed(tf) < -32'sd32768) tsat = 16'sh8000;
    else tsat = tf[15:0];
    if (pf[31]) psat = '0;
    else if (pf > {14'd0, PressMax}) psat = PressMax;
    else psat = pf[17:0];
  end
  localparam int unsigned OutW = 16 + 18 + 1;
  localparam int unsigned Pad = NStages - 12;
  logic [OutW-1:0] dl_q [Pad];
  always_ff @(posedge clk_i) if (en) begin
    dl_q[0] <= s12_err_q ? {16'd0, 18'd0, 1'b1} : {tsat, psat, 1'b0};
    for (int i = 1; i < Pad; i++) dl_q[i] <= dl_q[i-1];
  end
  assign out_ch.valid = v_q[Lat-1];
  assign {out_ch.temp_tenths, out_ch.press_pa, out_ch.div_error} = dl_q[Pad-1];

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.div_error |-> out_ch.press_pa == '0 && out_ch.temp_tenths == '0)
    else $error("error result not zeroed");
  a_skid_only_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> $past(out_full)) else $error("skid filled without stall");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_full |=> out_ch.valid && $stable(out_ch.press_pa)) else $error("result dropped");
`endif
endmodule

// File: hw/rtl/bpc_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
module bpc_div
  import bpc_pkg::*;
#(
  parameter int unsigned W  = 32,
  parameter int unsigned SW = 8
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [W-1:0]  num_i,
  input  logic [W-1:0]  den_i,
  input  logic [SW-1:0] side_i,
  output logic [W-1:0]  quo_o,
  output logic [SW-1:0] side_o
);
  logic [W-1:0]  rem_q  [W+1];
  logic [W-1:0]  num_q  [W+1];
  logic [W-1:0]  den_q  [W+1];
  logic [SW-1:0] side_q [W+1];

  assign rem_q[0]  = '0;
  assign num_q[0]  = num_i;
  assign den_q[0]  = den_i;
  assign side_q[0] = side_i;

  for (genvar i = 0; i < W; i++) begin : g_stage
    logic [W:0] trial;
    assign trial = {rem_q[i], num_q[i][W-1]} ;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (trial >= {1'b0, den_q[i]}) begin
          rem_q[i+1] <= W'(trial - {1'b0, den_q[i]});
          num_q[i+1] <= {num_q[i][W-2:0], 1'b1};
        end else begin
          rem_q[i+1] <= trial[W-1:0];
          num_q[i+1] <= {num_q[i][W-2:0], 1'b0};
        end
        den_q[i+1]  <= den_q[i];
        side_q[i+1] <= side_q[i];
      end
    end
  end

  assign quo_o  = num_q[W];
  assign side_o = side_q[W];
endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the barometric pressure compensation unit.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bpc_pkg::*;

  // Register indexes 5..7 do not exist; a write there must change nothing.
  localparam logic [2:0] RegNone = 3'd7;
  localparam int unsigned Drain = 100;  // a margin above the pipeline latency

  typedef struct {
    logic signed [15:0] temp_tenths;
    logic        [17:0] press_pa;
    logic               div_error;
  } reading_t;

  typedef struct {
    logic [15:0] raw_temp;
    logic [15:0] raw_press;
  } sample_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  bpc_in_if  in_ch();
  bpc_out_if out_ch();
  bpc_cfg_if cfg_ch();

  barometric_pressure_compensation_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #2 clk = ~clk;

  // Testbench copy of the calibration registers, updated on each cfg write to an existing index.
  logic [31:0] cal_regs [5];

  sample_t  samples_pending[$];     // raw readings not yet offered
  reading_t readings_due[$];        // compensated readings still to arrive
  int unsigned errors = 0;
  int unsigned src_idle = 11;       // percent of cycles the sender idles
  int unsigned snk_idle = 51;       // percent of cycles the receiver stalls
  int unsigned hold_left = 0;       // long receiver hold-off, in cycles
  bit in_fire = 1'b0;

  // Arithmetic right shift on a 32-bit word.
  function automatic logic [31:0] sra32(input logic [31:0] v, input int s);
    return v[31] ? ~((~v) >> s) : (v >> s);
  endfunction

  function automatic logic [31:0] sext(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  // Datasheet compensation, every intermediate wrapping at 32 bits.
  function automatic reading_t compensate(input sample_t s);
    reading_t r;
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [31:0] ut, up, x1, x2, x3, b3, b4, b5, b6, b7, p, sq, dv, tt;
    ac1 = sext(cal_regs[REG_AC1_AC2][31:16]);
    ac2 = sext(cal_regs[REG_AC1_AC2][15:0]);
    ac3 = sext(cal_regs[REG_AC3_AC4][31:16]);
    ac4 = {16'd0, cal_regs[REG_AC3_AC4][15:0]};
    ac5 = {16'd0, cal_regs[REG_AC5_AC6][31:16]};
    ac6 = {16'd0, cal_regs[REG_AC5_AC6][15:0]};
    b1  = sext(cal_regs[REG_B1_B2][31:16]);
    b2  = sext(cal_regs[REG_B1_B2][15:0]);
    mc  = sext(cal_regs[REG_MC_MD][31:16]);
    md  = sext(cal_regs[REG_MC_MD][15:0]);
    ut  = {16'd0, s.raw_temp};
    up  = {16'd0, s.raw_press};
    r.temp_tenths = '0;
    r.press_pa = '0;
    r.div_error = 1'b1;
    // temperature
    x1 = sra32((ut - ac6) * ac5, 15);
    dv = x1 + md;
    if (dv == 32'd0) return r;
    x2 = 32'($signed(mc * 32'd2048) / $signed(dv));
    b5 = x1 + x2;
    // pressure
    b6 = b5 - TempOffset;
    sq = sra32(b6 * b6, 12);
    x1 = sra32(b2 * sq, 11);
    x2 = sra32(ac2 * b6, 11);
    x3 = x1 + x2;
    b3 = sra32(ac1 * 32'd4 + x3 + 32'd2, 2);
    x1 = sra32(ac3 * b6, 13);
    x2 = sra32(b1 * sq, 16);
    x3 = sra32(x1 + x2 + 32'd2, 2);
    b4 = (ac4 * (x3 + B4Bias)) >> 15;
    if (b4 == 32'd0) return r;
    b7 = (up - b3) * PressScale;
    if (b7 < 32'h8000_0000) p = (b7 << 1) / b4;
    else p = (b7 / b4) << 1;
    x1 = sra32(p, 8) * sra32(p, 8);
    x1 = sra32(x1 * PcSq, 16);
    x2 = sra32(PcLinNeg * p, 16);
    p = p + sra32(x1 + x2 + PcOff, 4);
    // saturation
    tt = sra32(b5 + 32'd8, 4);
    if ($signed(tt) > 32767) tt = 32'd32767;
    else if ($signed(tt) < -32768) tt = 32'hFFFF_8000;
    if ($signed(p) < 0) p = 32'd0;
    else if ($signed(p) > 262143) p = 32'd262143;
    r.temp_tenths = tt[15:0];
    r.press_pa = p[17:0];
    r.div_error = 1'b0;
    return r;
  endfunction

  // Input side: record accepted readings and their predicted results.
  always @(posedge clk) begin
    in_fire = in_ch.valid && in_ch.ready;
    if (in_fire) begin
      sample_t s;
      s.raw_temp = in_ch.raw_temp;
      s.raw_press = in_ch.raw_press;
      readings_due.push_back(compensate(s));
    end
    if (cfg_ch.valid && cfg_ch.ready && cfg_ch.index <= REG_MC_MD)
      cal_regs[cfg_ch.index] <= cfg_ch.data;
  end

  // Driver: offers the next pending reading, or idles at random.
  always @(negedge clk) begin
    if (rst_n && (!in_ch.valid || in_fire)) begin
      if (samples_pending.size() > 0 && $urandom_range(99) >= src_idle) begin
        sample_t s;
        s = samples_pending.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.raw_temp <= s.raw_temp;
        in_ch.raw_press <= s.raw_press;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Long hold-off counter, separate from the random stalls.
  always @(negedge clk) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
  end

  always @(negedge clk) begin
    out_ch.ready <= rst_n && hold_left == 0 && $urandom_range(99) >= snk_idle;
  end

  // Monitor: compare each result transaction with the oldest prediction.
  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready) begin
      if (readings_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result t=%0d p=%0d e=%0b", $time,
                 out_ch.temp_tenths, out_ch.press_pa, out_ch.div_error);
      end else begin
        reading_t want;
        want = readings_due.pop_front();
        if (out_ch.temp_tenths !== want.temp_tenths) begin
          errors++;
          $display("%0t: temp_tenths expected %0d actual %0d", $time,
                   want.temp_tenths, out_ch.temp_tenths);
        end
        if (out_ch.press_pa !== want.press_pa) begin
          errors++;
          $display("%0t: press_pa expected %0d actual %0d", $time,
                   want.press_pa, out_ch.press_pa);
        end
        if (out_ch.div_error !== want.div_error) begin
          errors++;
          $display("%0t: div_error expected %0b actual %0b", $time,
                   want.div_error, out_ch.div_error);
        end
      end
    end
  end

  // One register write over the cfg channel.
  task automatic write_cal(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic load_cal(input logic [31:0] r0, r1, r2, r3, r4);
    write_cal(REG_AC1_AC2, r0);
    write_cal(REG_AC3_AC4, r1);
    write_cal(REG_AC5_AC6, r2);
    write_cal(REG_B1_B2, r3);
    write_cal(REG_MC_MD, r4);
  endtask

  task automatic queue_reading(input logic [15:0] t, input logic [15:0] p);
    sample_t s;
    s.raw_temp = t;
    s.raw_press = p;
    samples_pending.push_back(s);
  endtask

  // Block must be idle before any register write.
  task automatic wait_drained();
    wait (samples_pending.size() == 0);
    @(posedge clk);
    while (in_ch.valid || readings_due.size() != 0) @(posedge clk);
    repeat (Drain) @(posedge clk);
  endtask

  // Typical calibration with random jitter; small md jitter reaches the zero divisor.
  task automatic load_typical_jitter();
    logic [15:0] md;
    md = ($urandom_range(3) == 0) ? 16'($urandom_range(8)) : 16'd2868;
    load_cal({16'd408 + 16'($urandom_range(255)), 16'hFFB8 - 16'($urandom_range(63))},
             {16'hC7D1 + 16'($urandom_range(511)), 16'd32741 - 16'($urandom_range(4095))},
             {16'd32757 - 16'($urandom_range(8191)), 16'd23153 + 16'($urandom_range(4095))},
             {16'd6190 + 16'($urandom_range(1023)), 16'($urandom_range(15))},
             {16'hDDF9 + 16'($urandom_range(511)), md});
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.raw_temp = '0;
    in_ch.raw_press = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    for (int i = 0; i < 5; i++) cal_regs[i] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset calibration: ac5 and md are zero, so the temperature divisor is zero.
    queue_reading(16'd27898, 16'd23843);
    queue_reading(16'hFFFF, 16'h0000);
    wait_drained();

    // Datasheet calibration, directed corners of both raw fields.
    load_cal({16'd408, 16'hFFB8}, {16'hC7D1, 16'd32741}, {16'd32757, 16'd23153},
             {16'd6190, 16'd4}, {16'hDDF9, 16'd2868});
    write_cal(RegNone, 32'hDEAD_BEEF);  // nonexistent index, ignored
    queue_reading(16'd27898, 16'd23843);
    queue_reading(16'h0000, 16'h0000);
    queue_reading(16'hFFFF, 16'hFFFF);
    queue_reading(16'h0000, 16'hFFFF);
    queue_reading(16'hFFFF, 16'h0000);
    queue_reading(16'h5555, 16'hAAAA);
    queue_reading(16'hAAAA, 16'h5555);
    queue_reading(16'h8000, 16'h7FFF);
    wait_drained();

    // All ones: ac4 = 0xFFFF, mc and md are -1.
    load_cal('1, '1, '1, '1, '1);
    queue_reading(16'h0000, 16'hFFFF);
    queue_reading(16'hFFFF, 16'h0000);
    queue_reading(16'h7FFF, 16'h8000);
    wait_drained();

    // Most negative signed halves: drives temperature toward saturation.
    load_cal(32'h8000_8000, 32'h8000_8000, 32'h8000_8000, 32'h8000_8000, 32'h8000_0001);
    queue_reading(16'h0000, 16'h0000);
    queue_reading(16'hFFFF, 16'hFFFF);
    queue_reading(16'h1234, 16'hFEDC);
    wait_drained();

    // Most positive, and ac4 = 0 so b4 is zero.
    load_cal(32'h7FFF_7FFF, 32'h7FFF_0000, 32'h7FFF_7FFF, 32'h7FFF_7FFF, 32'h7FFF_7FFF);
    queue_reading(16'h4000, 16'h4000);
    queue_reading(16'hC000, 16'h0001);
    wait_drained();

    // Random part: nine phases, idling pattern changes every three.
    for (int ph = 0; ph < 9; ph++) begin
      if (ph < 3) begin
        src_idle = 11;
        snk_idle = 51;
      end else if (ph < 6) begin
        src_idle = 51;
        snk_idle = 11;
      end else begin
        src_idle = 0;
        snk_idle = 0;
      end
      if (ph % 3 == 2)
        load_cal($urandom, $urandom, $urandom, $urandom, $urandom);
      else
        load_typical_jitter();
      // Receiver stops for a long stretch while the sender keeps offering.
      if (ph == 6) hold_left = 400;
      for (int k = 0; k < 150; k++) begin
        if ($urandom_range(3) == 0)
          queue_reading(16'($urandom), 16'($urandom));
        else
          queue_reading(16'd27898 + 16'($urandom_range(8191)) - 16'd4096,
                        16'd23843 + 16'($urandom_range(16383)) - 16'd8192);
      end
      wait_drained();
    end

    if (errors == 0 && readings_due.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
